### hdl/chess_piece_attack_bitboard_core_assert.svh
// assertion macros for the attack bitboard core
`ifndef CHESS_PIECE_ATTACK_BITBOARD_CORE_ASSERT_SVH
`define CHESS_PIECE_ATTACK_BITBOARD_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define CPAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpab same-cycle check failed");

// next-cycle implication, held off during reset
`define CPAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpab next-cycle check failed");

`endif

### hdl/cpab_pkg.sv
package cpab_pkg;

  typedef logic [63:0] bb_t;
  typedef logic [5:0]  sq_t;
  typedef logic [2:0]  kind_t;
  typedef logic signed [4:0] delta_t;

  localparam kind_t KIND_KNIGHT = 3'd0;
  localparam kind_t KIND_BISHOP = 3'd1;
  localparam kind_t KIND_ROOK   = 3'd2;
  localparam kind_t KIND_QUEEN  = 3'd3;
  localparam kind_t KIND_KING   = 3'd4;

  localparam int unsigned NUM_OFF = 8;

  // row and column steps of the leaper offsets
  localparam delta_t KNIGHT_DR [NUM_OFF] = '{5'sd2, 5'sd2, 5'sd1, 5'sd1,
                                             -5'sd2, -5'sd2, -5'sd1, -5'sd1};
  localparam delta_t KNIGHT_DC [NUM_OFF] = '{-5'sd1, 5'sd1, -5'sd2, 5'sd2,
                                             5'sd1, -5'sd1, 5'sd2, -5'sd2};
  localparam delta_t KING_DR [NUM_OFF] = '{5'sd0, 5'sd0, -5'sd1, 5'sd1,
                                           -5'sd1, 5'sd1, -5'sd1, 5'sd1};
  localparam delta_t KING_DC [NUM_OFF] = '{-5'sd1, 5'sd1, 5'sd0, 5'sd0,
                                           5'sd1, -5'sd1, -5'sd1, 5'sd1};

  typedef struct packed {
    bb_t file_m;
    bb_t rank_m;
    bb_t diag_m;
    bb_t anti_m;
  } line_masks_t;

  function automatic bb_t byte_swap(input bb_t x);
    bb_t r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic bb_t bit_reverse(input bb_t x);
    bb_t r;
    for (int i = 0; i < 64; i++) begin
      r[i] = x[63-i];
    end
    return r;
  endfunction

endpackage

### hdl/cpab_masks.sv
module cpab_masks (
  input  cpab_pkg::sq_t         square,
  output cpab_pkg::bb_t         sq_bit,
  output cpab_pkg::line_masks_t masks
);
  import cpab_pkg::*;

  logic [2:0] row;
  logic [2:0] col;
  bb_t file_m;
  bb_t rank_m;
  bb_t diag_m;
  bb_t anti_m;
  bb_t self_m;

  assign row = square[5:3];
  assign col = square[2:0];

  for (genvar i = 0; i < 64; i++) begin : g_sq
    localparam logic [2:0] R = 3'(i / 8);
    localparam logic [2:0] C = 3'(i % 8);
    assign self_m[i] = (6'(i) == square);
    assign file_m[i] = (C == col) && !self_m[i];
    assign rank_m[i] = (R == row) && !self_m[i];
    assign diag_m[i] = (({1'b0, R} + {1'b0, col}) == ({1'b0, row} + {1'b0, C}))
                       && !self_m[i];
    assign anti_m[i] = (({1'b0, R} + {1'b0, C}) == ({1'b0, row} + {1'b0, col}))
                       && !self_m[i];
  end

  assign sq_bit = self_m;
  assign masks  = '{file_m: file_m, rank_m: rank_m, diag_m: diag_m, anti_m: anti_m};

endmodule

### hdl/cpab_line.sv
module cpab_line (
  input  cpab_pkg::bb_t occupancy,
  input  cpab_pkg::bb_t sq_bit,
  input  cpab_pkg::bb_t line_mask,
  input  logic          full_rev,
  output cpab_pkg::bb_t attacks
);
  import cpab_pkg::*;

  bb_t fwd;
  bb_t rev;
  bb_t rs;
  bb_t fwd_d;
  bb_t rev_d;
  bb_t rev_b;

  // hyperbola quintessence on one line
  assign fwd   = occupancy & line_mask;
  assign rev   = full_rev ? bit_reverse(fwd) : byte_swap(fwd);
  assign rs    = full_rev ? bit_reverse(sq_bit) : byte_swap(sq_bit);
  assign fwd_d = fwd - sq_bit;
  assign rev_d = rev - rs;
  assign rev_b = full_rev ? bit_reverse(rev_d) : byte_swap(rev_d);
  assign attacks = (fwd_d ^ rev_b) & line_mask;

endmodule

### hdl/cpab_leap.sv
module cpab_leap (
  input  cpab_pkg::sq_t square,
  output cpab_pkg::bb_t knight_set,
  output cpab_pkg::bb_t king_set
);
  import cpab_pkg::*;

  logic [NUM_OFF-1:0] knight_hit;
  logic [NUM_OFF-1:0] king_hit;
  sq_t                knight_sq [NUM_OFF];
  sq_t                king_sq   [NUM_OFF];

  for (genvar k = 0; k < NUM_OFF; k++) begin : g_off
    delta_t n_r;
    delta_t n_c;
    delta_t g_r;
    delta_t g_c;
    assign n_r = signed'({2'b00, square[5:3]}) + KNIGHT_DR[k];
    assign n_c = signed'({2'b00, square[2:0]}) + KNIGHT_DC[k];
    assign g_r = signed'({2'b00, square[5:3]}) + KING_DR[k];
    assign g_c = signed'({2'b00, square[2:0]}) + KING_DC[k];
    // on board when both coordinates stay in 0..7
    assign knight_hit[k] = (n_r[4:3] == 2'b00) && (n_c[4:3] == 2'b00);
    assign king_hit[k]   = (g_r[4:3] == 2'b00) && (g_c[4:3] == 2'b00);
    assign knight_sq[k]  = {n_r[2:0], n_c[2:0]};
    assign king_sq[k]    = {g_r[2:0], g_c[2:0]};
  end

  always_comb begin
    knight_set = '0;
    king_set   = '0;
    for (int k = 0; k < NUM_OFF; k++) begin
      if (knight_hit[k]) begin
        knight_set[knight_sq[k]] = 1'b1;
      end
      if (king_hit[k]) begin
        king_set[king_sq[k]] = 1'b1;
      end
    end
  end

endmodule

### hdl/chess_piece_attack_bitboard_core.sv
// attack and move bitboards for knight, bishop, rook, queen and king
// a start transfer is registered in the input stage, then the result stage registers the sets and raises out_strobe
// throughput: one query per cycle, busy stays low once out of reset
// the receiver cannot stall, every result shows for exactly one cycle
// reset (synchronous, rst_n low) clears the valid bits and holds busy high
module chess_piece_attack_bitboard_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  cpab_pkg::kind_t in_kind,
  input  cpab_pkg::sq_t   in_square,
  input  cpab_pkg::bb_t   in_occupancy,
  input  cpab_pkg::bb_t   in_own_pieces,
  output logic            out_strobe,
  output cpab_pkg::bb_t   out_attack_set,
  output cpab_pkg::bb_t   out_move_set
);
  import cpab_pkg::*;
  `include "chess_piece_attack_bitboard_core_assert.svh"

  logic        busy_r;
  logic        in_valid_r;
  kind_t       kind_r;
  sq_t         square_r;
  bb_t         occ_r;
  bb_t         own_r;
  logic        out_strobe_r;
  bb_t         attack_r;
  bb_t         move_r;
  bb_t         attack_nxt;

  bb_t         sq_bit;
  line_masks_t masks;
  bb_t         file_att;
  bb_t         rank_att;
  bb_t         diag_att;
  bb_t         anti_att;
  bb_t         knight_set;
  bb_t         king_set;
  bb_t         orth_att;
  bb_t         diag_all;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      in_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      in_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      kind_r   <= in_kind;
      square_r <= in_square;
      occ_r    <= in_occupancy;
      own_r    <= in_own_pieces;
    end
  end

  cpab_masks u_masks (
    .square (square_r),
    .sq_bit (sq_bit),
    .masks  (masks)
  );

  cpab_line u_file (
    .occupancy (occ_r),
    .sq_bit    (sq_bit),
    .line_mask (masks.file_m),
    .full_rev  (1'b0),
    .attacks   (file_att)
  );

  cpab_line u_rank (
    .occupancy (occ_r),
    .sq_bit    (sq_bit),
    .line_mask (masks.rank_m),
    .full_rev  (1'b1),
    .attacks   (rank_att)
  );

  cpab_line u_diag (
    .occupancy (occ_r),
    .sq_bit    (sq_bit),
    .line_mask (masks.diag_m),
    .full_rev  (1'b0),
    .attacks   (diag_att)
  );

  cpab_line u_anti (
    .occupancy (occ_r),
    .sq_bit    (sq_bit),
    .line_mask (masks.anti_m),
    .full_rev  (1'b0),
    .attacks   (anti_att)
  );

  cpab_leap u_leap (
    .square     (square_r),
    .knight_set (knight_set),
    .king_set   (king_set)
  );

  assign orth_att = file_att | rank_att;
  assign diag_all = diag_att | anti_att;

  always_comb begin
    case (kind_r)
      KIND_KNIGHT: attack_nxt = knight_set;
      KIND_BISHOP: attack_nxt = diag_all;
      KIND_ROOK:   attack_nxt = orth_att;
      KIND_QUEEN:  attack_nxt = diag_all | orth_att;
      KIND_KING:   attack_nxt = king_set;
      default:     attack_nxt = '0;
    endcase
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      attack_r <= attack_nxt;
      move_r   <= attack_nxt & ~own_r;
    end
  end

  assign busy           = busy_r;
  assign out_strobe     = out_strobe_r;
  assign out_attack_set = attack_r;
  assign out_move_set   = move_r;

  `CPAB_ASSERT_NEXT(a_accept_to_stage, clk, rst_n, start && !busy, in_valid_r)
  `CPAB_ASSERT_NEXT(a_stage_to_result, clk, rst_n, 1'b1, out_strobe_r == $past(in_valid_r))
  `CPAB_ASSERT_NOW(a_move_in_attack, clk, rst_n, out_strobe_r, (move_r & ~attack_r) == '0)

endmodule
